@@ design/srfp_pkg.sv @@
// Shared types and constants of the sensor response frame parser.
// Used by srfp_ram, srfp_ctrl and sensor_response_frame_parser_unit.
package srfp_pkg;

   localparam int MAX_FRAME_BYTES = 32;
   localparam int STORE_DEPTH     = 28;
   localparam int ADDR_W          = $clog2(STORE_DEPTH);
   localparam int COUNT_W         = 5;
   // Longest length byte accepted: limited by the frame size and the store depth.
   localparam int LEN_MAX = (MAX_FRAME_BYTES - 3 < STORE_DEPTH + 1) ?
                            (MAX_FRAME_BYTES - 3) : (STORE_DEPTH + 1);

   typedef logic [7:0]         byte_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_BAD_LENGTH   = 2'd1,
      STATUS_CMD_MISMATCH = 2'd2,
      STATUS_SUM_MISMATCH = 2'd3
   } status_type;

   localparam logic [1:0] CSR_HEAD_BYTE        = 2'd0;
   localparam logic [1:0] CSR_EXPECTED_COMMAND = 2'd1;
   localparam logic [1:0] CSR_PAYLOAD_CAPACITY = 2'd2;

   typedef struct packed {
      byte_type  head_byte;
      byte_type  expected_command;
      count_type payload_capacity;
   } cfg_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      byte_type wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } ram_req_type;

endpackage

@@ design/srfp_ram.sv @@
// Payload store: one write port and one registered read port.
// Depends on srfp_pkg for depth and types.
module srfp_ram (
   input  logic                 clock,
   input  srfp_pkg::ram_req_type ram_req,
   output srfp_pkg::byte_type   rd_data
);
   import srfp_pkg::*;

   byte_type mem [STORE_DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/srfp_ctrl.sv @@
// Frame parser state machine, checksum, payload store sequencing and
// the result register. Depends on srfp_pkg; drives srfp_ram.
module srfp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  srfp_pkg::cfg_type     cfg,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  srfp_pkg::byte_type    req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output srfp_pkg::status_type  rsp_status,
   output srfp_pkg::byte_type    rsp_payload_byte,
   output srfp_pkg::count_type   rsp_payload_index,
   output srfp_pkg::count_type   rsp_payload_count,
   output logic                  rsp_last,
   output srfp_pkg::ram_req_type ram_req,
   input  srfp_pkg::byte_type    ram_rd_data
);
   import srfp_pkg::*;

   typedef enum logic [2:0] {
      ST_HUNT, ST_LEN, ST_BODY, ST_SUM, ST_EMIT_RD, ST_EMIT_WR
   } state_type;

   state_type  state_ff, state_in;
   count_type  frame_len_ff, frame_len_in;
   count_type  seen_ff, seen_in;
   byte_type   sum_ff, sum_in;
   logic       cmd_ok_ff, cmd_ok_in;
   count_type  rd_idx_ff, rd_idx_in;
   count_type  count_ff, count_in;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   byte_type   rsp_byte_ff, rsp_byte_in;
   count_type  rsp_index_ff, rsp_index_in;
   count_type  rsp_count_ff, rsp_count_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       slot_free;
   logic       accept;
   logic       len_bad;
   count_type  seen_next;
   byte_type   sum_next;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = slot_free && (state_ff != ST_EMIT_RD) && (state_ff != ST_EMIT_WR);
   assign accept    = req_valid && req_ready;
   assign sum_next  = sum_ff + req_rx_byte;
   assign seen_next = seen_ff + count_type'(1);
   assign len_bad   = (req_rx_byte == 8'd0) ||
                      ({1'b0, req_rx_byte} > 9'(LEN_MAX)) ||
                      ({1'b0, req_rx_byte} > ({4'd0, cfg.payload_capacity} + 9'd1));

   always_comb begin
      state_in      = state_ff;
      frame_len_in  = frame_len_ff;
      seen_in       = seen_ff;
      sum_in        = sum_ff;
      cmd_ok_in     = cmd_ok_ff;
      rd_idx_in     = rd_idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      ram_req       = '0;

      unique case (state_ff)
         ST_HUNT: begin
            if (accept && req_rx_byte == cfg.head_byte) begin
               state_in  = ST_LEN;
               sum_in    = req_rx_byte;
               seen_in   = '0;
               cmd_ok_in = 1'b0;
            end
         end
         ST_LEN: begin
            if (accept) begin
               if (len_bad) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_BAD_LENGTH;
                  rsp_byte_in   = '0;
                  rsp_index_in  = '0;
                  rsp_count_in  = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_HUNT;
               end else begin
                  frame_len_in = req_rx_byte[COUNT_W-1:0];
                  sum_in       = sum_next;
                  seen_in      = '0;
                  state_in     = ST_BODY;
               end
            end
         end
         ST_BODY: begin
            if (accept) begin
               if (seen_ff == '0) begin
                  cmd_ok_in = (req_rx_byte == cfg.expected_command);
               end else begin
                  ram_req.wr_en   = 1'b1;
                  ram_req.wr_addr = ADDR_W'(seen_ff - count_type'(1));
                  ram_req.wr_data = req_rx_byte;
               end
               sum_in  = sum_next;
               seen_in = seen_next;
               if (seen_next >= frame_len_ff) begin
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            if (accept) begin
               rsp_byte_in  = '0;
               rsp_index_in = '0;
               rsp_count_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_HUNT;
               // A good frame makes head + length + body + checksum vanish mod 256.
               if (!cmd_ok_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_CMD_MISMATCH;
               end else if (sum_next != 8'd0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_SUM_MISMATCH;
               end else if (frame_len_ff == count_type'(1)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
               end else begin
                  count_in  = frame_len_ff - count_type'(1);
                  rd_idx_in = '0;
                  state_in  = ST_EMIT_RD;
               end
            end
         end
         ST_EMIT_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = ADDR_W'(rd_idx_ff);
            state_in        = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            // Read data holds in the store's output register until this transfer is loaded.
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_byte_in   = ram_rd_data;
               rsp_index_in  = rd_idx_ff;
               rsp_count_in  = count_ff;
               rsp_last_in   = (rd_idx_ff == count_ff - count_type'(1));
               if (rd_idx_ff == count_ff - count_type'(1)) begin
                  state_in = ST_HUNT;
               end else begin
                  rd_idx_in = rd_idx_ff + count_type'(1);
                  state_in  = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HUNT;
         frame_len_ff <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         cmd_ok_ff    <= 1'b0;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_len_ff <= frame_len_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         cmd_ok_ff    <= cmd_ok_in;
         rd_idx_ff    <= rd_idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_payload_byte  = rsp_byte_ff;
   assign rsp_payload_index = rsp_index_ff;
   assign rsp_payload_count = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

@@ design/sensor_response_frame_parser_unit.sv @@
// Sensor response frame parser: one received byte per transfer.
// Length, command and checksum errors give a result in the cycle after the byte's transfer.
// A good frame's payload is read back from the store byte by byte: a store read, then a load
// of the result register once it is free; input is held off during that burst.
// Synchronous reset returns the parser to hunting and its control and configuration registers
// to their defaults; the result fields other than valid and the payload store are not cleared.
module sensor_response_frame_parser_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  srfp_pkg::byte_type   csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  srfp_pkg::byte_type   req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output srfp_pkg::status_type rsp_status,
   output srfp_pkg::byte_type   rsp_payload_byte,
   output srfp_pkg::count_type  rsp_payload_index,
   output srfp_pkg::count_type  rsp_payload_count,
   output logic                 rsp_last
);
   import srfp_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   ram_req_type ram_req;
   byte_type    ram_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEAD_BYTE:        cfg_in.head_byte        = csr_wdata;
            CSR_EXPECTED_COMMAND: cfg_in.expected_command = csr_wdata;
            CSR_PAYLOAD_CAPACITY: cfg_in.payload_capacity = csr_wdata[COUNT_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_byte        <= 8'd64;
         cfg_ff.expected_command <= 8'd4;
         cfg_ff.payload_capacity <= count_type'(4);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srfp_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_count (rsp_payload_count),
      .rsp_last          (rsp_last),
      .ram_req           (ram_req),
      .ram_rd_data       (ram_rd_data)
   );

   srfp_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

endmodule
